>>> sv/ttd_pkg.sv
// Package for the tick task dispatcher: command and status codes, queue item type.
// No dependencies; the front, queue, back, top level and testbench import it.
`timescale 1ns / 1ps

package ttd_pkg;

	localparam int MAX_TASKS = 16;
	localparam int LOCK_BITS = 8;

	localparam int SLOT_W  = 4;
	localparam int FLAGS_W = 9;
	localparam int UMASK_W = 8;
	localparam int TIME_W  = 32;
	localparam int HALF_W  = 16;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_UNLOCK = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE   = 3'd0,
		ST_FULL   = 3'd1,
		ST_IDLE   = 3'd2,
		ST_FIRED  = 3'd3,
		ST_NOSLOT = 3'd4
	} status_t;

	// One classified transaction as it travels from front to back
	typedef struct packed {
		cmd_t                cmd;
		logic [TIME_W-1:0]   delay;
		logic [FLAGS_W-1:0]  flags;
		logic [SLOT_W-1:0]   sel;
		logic [UMASK_W-1:0]  umask;
		logic [TIME_W-1:0]   now;
	} item_t;

	// One task table entry
	typedef struct packed {
		logic [TIME_W-1:0]   start;
		logic [TIME_W-1:0]   delay;
		logic [FLAGS_W-1:0]  flags;
	} entry_t;

endpackage

>>> sv/ttd_req_if.sv
// Request channel of the tick task dispatcher: valid/ready plus command fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface ttd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] delay_count;
	logic [15:0] unit_multiplier;
	logic [8:0]  task_flags;
	logic [3:0]  slot_select;
	logic [7:0]  unlock_mask;
	logic [31:0] now_time;

	modport source (output valid, cmd, delay_count, unit_multiplier, task_flags,
		slot_select, unlock_mask, now_time, input ready);
	modport sink (input valid, cmd, delay_count, unit_multiplier, task_flags,
		slot_select, unlock_mask, now_time, output ready);
endinterface

>>> sv/ttd_rsp_if.sv
// Response channel of the tick task dispatcher: valid/ready plus status and slot.
// Depends on nothing.
`timescale 1ns / 1ps

interface ttd_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] slot_id;

	modport source (output valid, status, slot_id, input ready);
	modport sink (input valid, status, slot_id, output ready);
endinterface

>>> sv/ttd_front.sv
// Front stage: accepts request transactions, decodes the command and forms the delay.
// Depends on ttd_pkg and ttd_req_if.
`timescale 1ns / 1ps

module ttd_front
	import ttd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ttd_req_if.sink    req,
	output logic       item_valid,
	input  logic       item_ready,
	output item_t      item
);

	logic  valid_s1;
	item_t item_s1;

	assign req.ready  = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// Hold a transaction until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Decode and scale the delay by the unit
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.cmd   <= cmd_t'(req.cmd);
			item_s1.delay <= TIME_W'(req.delay_count) * TIME_W'(req.unit_multiplier);
			item_s1.flags <= req.task_flags;
			item_s1.sel   <= req.slot_select;
			item_s1.umask <= req.unlock_mask;
			item_s1.now   <= req.now_time;
		end
	end

endmodule

>>> sv/ttd_queue.sv
// Two-entry queue between the front and back parts.
// Depends on ttd_pkg.
`timescale 1ns / 1ps

module ttd_queue
	import ttd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);

	item_t      slots_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_item   = slots_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
		end
	end

	// Store an incoming transaction
	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_q] <= push_item;
	end

endmodule

>>> sv/ttd_back.sv
// Back part: task table, insertion order list, lock state and the ordered tick walk.
// Depends on ttd_pkg and ttd_rsp_if.
`timescale 1ns / 1ps

module ttd_back
	import ttd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  item_t     q_item,
	output logic      q_pop,
	ttd_rsp_if.source rsp
);

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_RESULT
	} state_t;

	state_t                state_q;
	item_t                 op_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic [MAX_TASKS-1:0]  used_q;
	logic [LOCK_BITS-1:0]  held_q;
	logic [TIME_W-1:0]     last_q;
	logic [SW-1:0]         order_q [MAX_TASKS];
	entry_t                mem [MAX_TASKS];
	entry_t                rd_s1;
	logic                  ev_valid_s1;
	logic [SW-1:0]         ev_pos_s1;
	logic [SW-1:0]         ev_slot_s1;
	status_t               res_status_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [SLOT_W-1:0]     out_slot_q;

	logic                  free_found;
	logic [SW-1:0]         free_idx;
	logic                  full;
	logic [SW-1:0]         ptr_idx;
	logic [SW-1:0]         cnt_idx;
	logic                  walk_end;
	logic [SW-1:0]         q_sel_idx;
	logic                  q_sel_ok;
	logic [SW-1:0]         op_sel_idx;
	logic                  rm_hit;
	logic [31:0]           fl_ext;
	logic [LOCK_BITS-1:0]  ev_locks;
	logic                  ev_rep;
	logic                  due;
	logic                  fire;
	logic [31:0]           um_ext;
	logic                  mem_we;
	logic [SW-1:0]         mem_wa;
	entry_t                mem_wd;
	logic                  app_en;
	logic                  drop_en;
	logic [SW-1:0]         drop_pos;
	logic                  is_add;

	assign ptr_idx    = ptr_q[SW-1:0];
	assign cnt_idx    = count_q[SW-1:0];
	assign walk_end   = (ptr_q >= count_q);
	assign q_sel_idx  = SW'(32'(q_item.sel));
	assign q_sel_ok   = (32'(q_item.sel) < MAX_TASKS) && used_q[q_sel_idx];
	assign op_sel_idx = SW'(32'(op_q.sel));
	assign rm_hit     = !walk_end && (order_q[ptr_idx] == op_sel_idx);
	assign fl_ext     = 32'(rd_s1.flags);
	assign ev_locks   = fl_ext[LOCK_BITS-1:0];
	assign ev_rep     = fl_ext[LOCK_BITS];
	assign um_ext     = 32'(q_item.umask);
	assign due        = ((op_q.now - rd_s1.start) >= rd_s1.delay);
	assign fire       = (state_q == S_WALK) && (op_q.cmd == CMD_TICK) && ev_valid_s1
		&& used_q[ev_slot_s1] && due && ((held_q & ev_locks) == '0);
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign full       = !free_found || (count_q >= CW'(MAX_TASKS));
	assign is_add     = q_pop && (q_item.cmd == CMD_ADD) && !full;

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.slot_id = out_slot_q;

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// Select table and order list writes
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = free_idx;
		mem_wd   = '{start: q_item.now, delay: q_item.delay, flags: q_item.flags};
		app_en   = is_add;
		drop_en  = 1'b0;
		drop_pos = ev_pos_s1;
		if (is_add) begin
			mem_we = 1'b1;
		end else if (fire && ev_rep) begin
			mem_we = 1'b1;
			mem_wa = ev_slot_s1;
			mem_wd = '{start: op_q.now, delay: rd_s1.delay, flags: rd_s1.flags};
		end
		if (fire && !ev_rep) begin
			drop_en = 1'b1;
		end else if (state_q == S_WALK && op_q.cmd == CMD_REMOVE && rm_hit) begin
			drop_en  = 1'b1;
			drop_pos = ptr_idx;
		end
	end

	// Task table memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[order_q[ptr_idx]];
	end

	// Order list: append at the tail, close the gap on a drop
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_TASKS; j++) begin
			if (app_en && SW'(j) == cnt_idx) begin
				order_q[j] <= free_idx;
			end else if (drop_en && j < MAX_TASKS - 1 && SW'(j) >= drop_pos) begin
				order_q[j] <= order_q[(j < MAX_TASKS - 1) ? j + 1 : j];
			end
		end
	end

	// Sequencer: command execution, walk and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			used_q       <= '0;
			held_q       <= '0;
			last_q       <= '0;
			ev_valid_s1  <= 1'b0;
			ev_pos_s1    <= '0;
			ev_slot_s1   <= '0;
			op_q         <= '0;
			res_status_q <= ST_DONE;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_DONE;
			out_slot_q   <= '0;
		end else begin
			if (rsp.ready && state_q != S_RESULT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_q    <= q_item;
						state_q <= S_RESULT;
						unique case (q_item.cmd)
							CMD_ADD: begin
								if (full) begin
									res_status_q <= ST_FULL;
									res_slot_q   <= '0;
								end else begin
									used_q[free_idx] <= 1'b1;
									count_q          <= count_q + CW'(1);
									res_status_q     <= ST_DONE;
									res_slot_q       <= SLOT_W'(free_idx);
								end
							end
							CMD_REMOVE: begin
								if (q_sel_ok) begin
									ptr_q   <= '0;
									state_q <= S_WALK;
								end else begin
									res_status_q <= ST_NOSLOT;
									res_slot_q   <= '0;
								end
							end
							CMD_UNLOCK: begin
								held_q       <= held_q & ~um_ext[LOCK_BITS-1:0];
								res_status_q <= ST_DONE;
								res_slot_q   <= '0;
							end
							CMD_TICK: begin
								res_status_q <= ST_IDLE;
								res_slot_q   <= '0;
								if (q_item.now != last_q) begin
									last_q      <= q_item.now;
									ptr_q       <= '0;
									ev_valid_s1 <= 1'b0;
									state_q     <= S_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (op_q.cmd == CMD_REMOVE) begin
						if (walk_end || rm_hit) begin
							used_q[op_sel_idx] <= 1'b0;
							if (rm_hit) count_q <= count_q - CW'(1);
							res_status_q <= ST_DONE;
							res_slot_q   <= op_q.sel;
							state_q      <= S_RESULT;
						end else begin
							ptr_q <= ptr_q + CW'(1);
						end
					end else if (fire) begin
						held_q <= held_q | ev_locks;
						if (!ev_rep) begin
							used_q[ev_slot_s1] <= 1'b0;
							count_q            <= count_q - CW'(1);
						end
						res_status_q <= ST_FIRED;
						res_slot_q   <= SLOT_W'(ev_slot_s1);
						state_q      <= S_RESULT;
					end else if (!ev_valid_s1 && walk_end) begin
						res_status_q <= ST_IDLE;
						res_slot_q   <= '0;
						state_q      <= S_RESULT;
					end else if (!walk_end) begin
						ev_valid_s1 <= 1'b1;
						ev_pos_s1   <= ptr_idx;
						ev_slot_s1  <= order_q[ptr_idx];
						ptr_q       <= ptr_q + CW'(1);
					end else begin
						ev_valid_s1 <= 1'b0;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("entry count exceeds table size");
	a_count_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(used_q) == 32'(count_q))
		else $error("used slots and order length disagree");
	a_walk_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> op_q.cmd == CMD_REMOVE || op_q.cmd == CMD_TICK)
		else $error("walk entered for a command without one");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != S_IDLE)
		else $error("popped transaction produced no work");
`endif

endmodule

>>> sv/tick_task_dispatcher.sv
// Tick task dispatcher top level: front decode, two-entry queue, back execution.
// Path: add, unlock and early-out ticks pass the front register, the queue and the back result and output
// registers to result valid; remove and tick first walk the order list entry by entry.
// Throughput: one transaction at a time in the back part, set by the order walk.
// Reset: arst_n clears slot-used bits, entry count, held locks, last time, queues.
`timescale 1ns / 1ps

module tick_task_dispatcher
	import ttd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ttd_req_if.sink   req,
	ttd_rsp_if.source rsp
);

	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	ttd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	ttd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	ttd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

>>> sim/tb_tick_task_dispatcher.sv
// Self-checking testbench for the tick task dispatcher: directed table then random traffic.
// Depends on ttd_pkg, ttd_req_if, ttd_rsp_if and tick_task_dispatcher.
`timescale 1ns / 1ps

module tb_tick_task_dispatcher;
	import ttd_pkg::*;

	localparam int NTASK = 16;
	localparam int RAND_ITEMS = 1330;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] dcount;
		logic [15:0] umul;
		logic [8:0]  flags;
		logic [3:0]  sel;
		logic [7:0]  umask;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] slot;
	} rsp_t;

	// Directed row: request plus optional typed-in expectation
	typedef struct packed {
		req_t  rq;
		logic  fixed;
		rsp_t  rs;
	} row_t;

	logic clk;
	logic arst_n;
	ttd_req_if req ();
	ttd_rsp_if rsp ();

	tick_task_dispatcher u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// Shadow copy of the task table
	logic [31:0] tbl_start [NTASK];
	logic [31:0] tbl_delay [NTASK];
	logic [8:0]  tbl_flags [NTASK];
	logic        tbl_used  [NTASK];
	logic [3:0]  run_order [NTASK];
	int          run_count;
	logic [7:0]  locks_held;
	logic [31:0] tick_last;

	rsp_t   expected_rsp [$];
	int     errors;
	longint cycles;
	logic   stim_done;
	row_t   dir_rows [$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Remove an order position and close the gap
	function automatic void order_drop(int pos);
		for (int i = pos; i + 1 < run_count; i++) run_order[i] = run_order[i + 1];
		run_count--;
	endfunction

	// Advance the shadow table by one transaction and return its result
	function automatic rsp_t dispatch_predict(req_t r);
		rsp_t o;
		int   free_slot;
		logic [7:0] lk;
		logic [3:0] s;
		o.status = ST_DONE;
		o.slot   = '0;
		free_slot = -1;
		case (r.cmd)
			CMD_ADD: begin
				for (int i = NTASK - 1; i >= 0; i--) if (!tbl_used[i]) free_slot = i;
				if (free_slot < 0 || run_count >= NTASK) begin
					o.status = ST_FULL;
				end else begin
					tbl_start[free_slot] = r.now;
					tbl_delay[free_slot] = 32'(r.dcount) * 32'(r.umul);
					tbl_flags[free_slot] = r.flags;
					tbl_used[free_slot]  = 1'b1;
					run_order[run_count] = 4'(free_slot);
					run_count++;
					o.slot = 4'(free_slot);
				end
			end
			CMD_REMOVE: begin
				if (tbl_used[r.sel]) begin
					for (int i = 0; i < run_count; i++)
						if (run_order[i] == r.sel) begin
							order_drop(i);
							break;
						end
					tbl_used[r.sel] = 1'b0;
					o.slot = r.sel;
				end else begin
					o.status = ST_NOSLOT;
				end
			end
			CMD_UNLOCK: locks_held &= ~r.umask;
			default: begin
				o.status = ST_IDLE;
				if (r.now != tick_last) begin
					tick_last = r.now;
					for (int i = 0; i < run_count; i++) begin
						s = run_order[i];
						if (!tbl_used[s]) continue;
						if (32'(r.now - tbl_start[s]) < tbl_delay[s]) continue;
						lk = tbl_flags[s][7:0];
						if ((locks_held & lk) != 0) continue;
						locks_held |= lk;
						if (!tbl_flags[s][8]) begin
							order_drop(i);
							tbl_used[s] = 1'b0;
						end else begin
							tbl_start[s] = r.now;
						end
						o.status = ST_FIRED;
						o.slot = s;
						break;
					end
				end
			end
		endcase
		return o;
	endfunction

	function automatic req_t mk(cmd_t c, int dc, int um, int fl, int sl, int mk_, int nw);
		req_t r;
		r.cmd = c; r.dcount = 16'(dc); r.umul = 16'(um); r.flags = 9'(fl);
		r.sel = 4'(sl); r.umask = 8'(mk_); r.now = 32'(nw);
		return r;
	endfunction

	function automatic void row(req_t r, logic f, status_t st, int sl);
		row_t w;
		w.rq = r; w.fixed = f; w.rs.status = st; w.rs.slot = 4'(sl);
		dir_rows.push_back(w);
	endfunction

	// Random request, mostly well-formed near the shadow time
	function automatic req_t rand_req();
		req_t r;
		int   p;
		r = '0;
		p = $urandom_range(99);
		r.dcount = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8));
		r.umul   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
		if (r.umul == 16'd0) r.umul = 16'd1;
		r.flags  = ($urandom_range(3) == 0) ? 9'($urandom) :
			{1'($urandom), 8'(1 << $urandom_range(7)) & 8'($urandom)};
		r.sel    = 4'($urandom);
		r.umask  = 8'($urandom);
		r.now    = ($urandom_range(19) == 0) ? $urandom : tick_last + $urandom_range(0, 6);
		if (p < 30) r.cmd = CMD_ADD;
		else if (p < 42) r.cmd = CMD_REMOVE;
		else if (p < 55) r.cmd = CMD_UNLOCK;
		else r.cmd = CMD_TICK;
		return r;
	endfunction

	// Drive one transaction, with burst gaps on the sender side
	task automatic send_req(req_t r);
		if ($urandom_range(5) == 0)
			repeat ($urandom_range(1, 6)) @(negedge clk) req.valid <= 1'b0;
		@(negedge clk);
		req.valid <= 1'b1;
		req.cmd <= r.cmd; req.delay_count <= r.dcount; req.unit_multiplier <= r.umul;
		req.task_flags <= r.flags; req.slot_select <= r.sel;
		req.unlock_mask <= r.umask; req.now_time <= r.now;
		do @(posedge clk); while (!req.ready);
	endtask

	// Sender: directed table, then random traffic
	initial begin
		rsp_t p;
		req_t r;
		errors = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_ADD; req.delay_count = '0; req.unit_multiplier = 16'd1;
		req.task_flags = '0; req.slot_select = '0; req.unlock_mask = '0; req.now_time = '0;
		for (int i = 0; i < NTASK; i++) begin
			tbl_used[i] = 1'b0; tbl_start[i] = '0; tbl_delay[i] = '0;
			tbl_flags[i] = '0; run_order[i] = '0;
		end
		run_count = 0; locks_held = '0; tick_last = '0;

		// Directed cases: empty table, zero time, extremes, locks, full table
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 0), 1, ST_IDLE, 0);
		row(mk(CMD_REMOVE, 0, 1, 0, 15, 0, 0), 1, ST_NOSLOT, 0);
		row(mk(CMD_UNLOCK, 0, 1, 0, 0, 255, 0), 1, ST_DONE, 0);
		row(mk(CMD_ADD, 0, 1, 9'h001, 0, 0, 0), 1, ST_DONE, 0);
		row(mk(CMD_ADD, 0, 65535, 9'h101, 0, 0, 0), 1, ST_DONE, 1);
		row(mk(CMD_ADD, 65535, 65535, 9'h1FE, 0, 0, -1), 1, ST_DONE, 2);
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 5), 1, ST_FIRED, 0);
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 5), 1, ST_IDLE, 0);
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 6), 1, ST_IDLE, 0);
		row(mk(CMD_UNLOCK, 0, 1, 0, 0, 1, 7), 1, ST_DONE, 0);
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 7), 0, ST_DONE, 0);
		row(mk(CMD_REMOVE, 0, 1, 0, 1, 0, 0), 1, ST_DONE, 1);
		row(mk(CMD_REMOVE, 0, 1, 0, 1, 0, 0), 1, ST_NOSLOT, 0);
		row(mk(CMD_UNLOCK, 0, 1, 0, 0, 255, 0), 1, ST_DONE, 0);
		for (int i = 0; i < 16; i++) row(mk(CMD_ADD, 3, 2, 9'h100, 0, 0, 100), 0, ST_DONE, 0);
		row(mk(CMD_ADD, 1, 1, 0, 0, 0, 100), 1, ST_FULL, 0);
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 106), 0, ST_DONE, 0);
		row(mk(CMD_REMOVE, 0, 1, 0, 7, 0, 0), 1, ST_DONE, 7);
		row(mk(CMD_TICK, 0, 1, 0, 0, 0, 32'hFFFF_FFF0), 0, ST_DONE, 0);

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (dir_rows[k]) begin
			p = dispatch_predict(dir_rows[k].rq);
			if (dir_rows[k].fixed && p != dir_rows[k].rs)
				$display("%0t directed row %0d typed result %0h differs from prediction %0h",
					$time, k, dir_rows[k].rs, p);
			expected_rsp.push_back(dir_rows[k].fixed ? dir_rows[k].rs : p);
			send_req(dir_rows[k].rq);
		end
		for (int k = 0; k < RAND_ITEMS; k++) begin
			r = rand_req();
			expected_rsp.push_back(dispatch_predict(r));
			send_req(r);
		end
		@(negedge clk) req.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver stall pattern: calm stretches and busy stretches
	initial begin
		int phase;
		rsp.ready = 1'b0;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if ((phase % 512) < 128) rsp.ready <= 1'b1;
			else rsp.ready <= ($urandom_range(2) != 0);
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected result status=%0d slot=%0d",
					$time, rsp.status, rsp.slot_id);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, want.status, rsp.status);
					errors++;
				end
				if (rsp.slot_id !== want.slot) begin
					$display("%0t slot_id mismatch: expected %0d actual %0d",
						$time, want.slot, rsp.slot_id);
					errors++;
				end
			end
		end
	end

	// Watchdog and end of run
	initial begin
		cycles = 0;
		fork
			begin
				wait (stim_done === 1'b1);
				while (expected_rsp.size() != 0) @(posedge clk);
				repeat (40) @(posedge clk);
			end
			begin
				while (cycles < CYCLE_LIMIT) begin
					@(posedge clk);
					cycles++;
				end
				errors = -1;
			end
		join_any
		if (errors < 0) begin
			$display("%0t timeout with %0d results outstanding", $time, expected_rsp.size());
			$display("tick_task_dispatcher verification failed");
		end else if (errors == 0) begin
			$display("tick_task_dispatcher verification clean");
		end else begin
			$display("tick_task_dispatcher verification failed");
		end
		$finish;
	end

endmodule
